// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RGB to HSV converter core.
// No dependencies; the including module must provide i_clk and i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside of reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Check a property on every clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ===== rtl/rgbhsv_pkg.sv =====
// Shared types and constants for the RGB to HSV converter.
// No dependencies; used by every module under rtl.
`timescale 1ns / 1ps

package rgbhsv_pkg;

    localparam int unsigned CH_W      = 8;   // channel byte
    localparam int unsigned HUE_W     = 15;  // hue, 64ths of a degree
    localparam int unsigned SAT_W     = 13;  // saturation, 4096 = 1.0
    localparam int unsigned QUOT_W    = 13;  // quotient bits, one per divider cell
    localparam int unsigned SAT_SHIFT = 12;  // 4096 = 1 << 12
    localparam int unsigned DIVD_W    = CH_W + SAT_SHIFT; // dividend width

    localparam logic [HUE_W-1:0] SECTOR_SPAN = HUE_W'(60 * 64);
    localparam logic [HUE_W-1:0] BASE_RED    = HUE_W'(0);
    localparam logic [HUE_W-1:0] BASE_GREEN  = HUE_W'(2 * 60 * 64);
    localparam logic [HUE_W-1:0] BASE_BLUE   = HUE_W'(4 * 60 * 64);
    localparam logic [HUE_W-1:0] FULL_TURN   = HUE_W'(360 * 64);
    localparam logic [SAT_W-1:0] SAT_ONE     = SAT_W'(4096);

    // One long-division lane: running remainder, divisor, quotient so far.
    typedef struct packed {
        logic [DIVD_W-1:0] rem;
        logic [CH_W-1:0]   div;
        logic [QUOT_W-1:0] quo;
    } t_lane;

    // Side information that rides along the divider chain.
    typedef struct packed {
        logic             hue_en;  // delta is nonzero
        logic             sat_en;  // maximum is nonzero
        logic             neg;     // hue numerator is negative
        logic [HUE_W-1:0] base;    // sector offset added to the signed quotient
        logic [CH_W-1:0]  bright;  // largest channel
    } t_side;

    typedef struct packed {
        t_lane hue;
        t_lane sat;
        t_side side;
    } t_cell_data;

endpackage

// ===== rtl/rgbhsv_div_cell.sv =====
// One restoring-division cell: settles one quotient bit for both the hue and
// saturation lanes and registers the result. Depends on rgbhsv_pkg.
`timescale 1ns / 1ps

module rgbhsv_div_cell #(
    parameter int unsigned BIT = 0
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  rgbhsv_pkg::t_cell_data  i_data,
    output logic                    o_valid,
    output rgbhsv_pkg::t_cell_data  o_data
);

    localparam int unsigned DW = rgbhsv_pkg::DIVD_W;
    localparam int unsigned CW = rgbhsv_pkg::CH_W;

    // Try to subtract divisor << BIT; keep the difference when it does not borrow.
    function automatic rgbhsv_pkg::t_lane step(input rgbhsv_pkg::t_lane lane);
        logic [DW:0]         trial;
        rgbhsv_pkg::t_lane   res;
        trial = {1'b0, lane.rem} - ({1'b0, {(DW - CW){1'b0}}, lane.div} << BIT);
        res     = lane;
        res.quo = {lane.quo[rgbhsv_pkg::QUOT_W-2:0], ~trial[DW]};
        if (!trial[DW]) begin
            res.rem = trial[DW-1:0];
        end
        return res;
    endfunction

    logic                   r_valid;
    rgbhsv_pkg::t_cell_data r_data;
    rgbhsv_pkg::t_cell_data n_data;

    always_comb begin
        n_data      = i_data;
        n_data.hue  = step(i_data.hue);
        n_data.sat  = step(i_data.sat);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== rtl/rgbhsv_front.sv =====
// Front stage: max, min, delta, hue sector and the scaled dividends.
// Depends on rgbhsv_pkg.
`timescale 1ns / 1ps

module rgbhsv_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic [rgbhsv_pkg::CH_W-1:0]       i_red,
    input  logic [rgbhsv_pkg::CH_W-1:0]       i_green,
    input  logic [rgbhsv_pkg::CH_W-1:0]       i_blue,
    output logic                              o_valid,
    output rgbhsv_pkg::t_cell_data            o_data
);

    localparam int unsigned CW = rgbhsv_pkg::CH_W;
    localparam int unsigned DW = rgbhsv_pkg::DIVD_W;

    logic [CW-1:0]          w_max;
    logic [CW-1:0]          w_min;
    logic [CW-1:0]          w_delta;
    logic [CW:0]            w_num;   // signed hue numerator
    logic [CW-1:0]          w_abs;
    logic [DW-1:0]          w_hue_dvd;
    logic [rgbhsv_pkg::HUE_W-1:0] w_base;

    logic                   r_valid;
    rgbhsv_pkg::t_cell_data r_data;
    rgbhsv_pkg::t_cell_data n_data;

    always_comb begin
        w_max = i_red;
        if (i_green > w_max) w_max = i_green;
        if (i_blue > w_max)  w_max = i_blue;
        w_min = i_red;
        if (i_green < w_min) w_min = i_green;
        if (i_blue < w_min)  w_min = i_blue;
        w_delta = w_max - w_min;

        // Sector priority: red, then green, then blue.
        if (w_max == i_red) begin
            w_num  = {1'b0, i_green} - {1'b0, i_blue};
            w_base = w_num[CW] ? rgbhsv_pkg::FULL_TURN : rgbhsv_pkg::BASE_RED;
        end else if (w_max == i_green) begin
            w_num  = {1'b0, i_blue} - {1'b0, i_red};
            w_base = rgbhsv_pkg::BASE_GREEN;
        end else begin
            w_num  = {1'b0, i_red} - {1'b0, i_green};
            w_base = rgbhsv_pkg::BASE_BLUE;
        end
        w_abs     = w_num[CW] ? CW'(-w_num) : w_num[CW-1:0];
        w_hue_dvd = DW'(w_abs) * DW'(rgbhsv_pkg::SECTOR_SPAN);

        n_data.hue.rem     = w_hue_dvd;
        n_data.hue.div     = w_delta;
        n_data.hue.quo     = '0;
        n_data.sat.rem     = {w_delta, {rgbhsv_pkg::SAT_SHIFT{1'b0}}};
        n_data.sat.div     = w_max;
        n_data.sat.quo     = '0;
        n_data.side.hue_en = (w_delta != '0);
        n_data.side.sat_en = (w_max != '0);
        n_data.side.neg    = w_num[CW];
        n_data.side.base   = w_base;
        n_data.side.bright = w_max;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== rtl/rgbhsv_back.sv =====
// Back stage: fold the quotients into hue and saturation and register them.
// Depends on rgbhsv_pkg.
`timescale 1ns / 1ps

module rgbhsv_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  rgbhsv_pkg::t_cell_data            i_data,
    output logic                              o_valid,
    output logic [rgbhsv_pkg::HUE_W-1:0]      o_hue,
    output logic [rgbhsv_pkg::SAT_W-1:0]      o_saturation,
    output logic [rgbhsv_pkg::CH_W-1:0]       o_brightness
);

    localparam int unsigned HW = rgbhsv_pkg::HUE_W;

    logic [HW-1:0]               w_mag;
    logic [HW-1:0]               n_hue;
    logic [rgbhsv_pkg::SAT_W-1:0] n_sat;

    logic                         r_valid;
    logic [HW-1:0]                r_hue;
    logic [rgbhsv_pkg::SAT_W-1:0] r_sat;
    logic [rgbhsv_pkg::CH_W-1:0]  r_bright;

    always_comb begin
        // Floor toward minus infinity: a negative quotient with a remainder
        // rounds one further down.
        w_mag = HW'(i_data.hue.quo);
        if (!i_data.side.hue_en) begin
            n_hue = '0;
        end else if (i_data.side.neg) begin
            n_hue = i_data.side.base - w_mag - HW'(i_data.hue.rem != '0);
        end else begin
            n_hue = i_data.side.base + w_mag;
        end
        n_sat = i_data.side.sat_en ? i_data.sat.quo : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_hue    <= n_hue;
        r_sat    <= n_sat;
        r_bright <= i_data.side.bright;
    end

    assign o_valid      = r_valid;
    assign o_hue        = r_hue;
    assign o_saturation = r_sat;
    assign o_brightness = r_bright;

endmodule

// ===== rtl/rgb_to_hsv_converter_core.sv =====
// RGB to HSV converter: a pixel passes from the start transfer to o_valid through the
// front stage, 13 divider cells and the output stage; throughput one pixel per cycle.
// The cell count is set by the 13-bit quotient, one quotient bit per cell.
// busy is always low and the receiver cannot stall; o_valid pulses for one cycle.
// Reset (synchronous, active low) flushes every valid bit; data regs are not reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rgb_to_hsv_converter_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [rgbhsv_pkg::CH_W-1:0]       i_red,
    input  logic [rgbhsv_pkg::CH_W-1:0]       i_green,
    input  logic [rgbhsv_pkg::CH_W-1:0]       i_blue,
    output logic                              o_valid,
    output logic [rgbhsv_pkg::HUE_W-1:0]      o_hue,
    output logic [rgbhsv_pkg::SAT_W-1:0]      o_saturation,
    output logic [rgbhsv_pkg::CH_W-1:0]       o_brightness
);

    localparam int unsigned NCELL = rgbhsv_pkg::QUOT_W;

    // Valid and data between stages: index 0 leaves the front stage,
    // index NCELL leaves the last divider cell.
    logic                   w_valid [0:NCELL];
    rgbhsv_pkg::t_cell_data w_data  [0:NCELL];
    logic                   w_accept;

    // The pipeline never backs up, so take a pixel on every cycle.
    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    // Compute max, min, delta, sector and the two dividends.
    rgbhsv_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_red   (i_red),
        .i_green (i_green),
        .i_blue  (i_blue),
        .o_valid (w_valid[0]),
        .o_data  (w_data[0])
    );

    // Chain of division cells, most significant quotient bit first. Each
    // cell hands its remainders and partial quotients to the next one.
    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        rgbhsv_div_cell #(
            .BIT (NCELL - 1 - k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .i_data  (w_data[k]),
            .o_valid (w_valid[k+1]),
            .o_data  (w_data[k+1])
        );
    end

    // Apply sector offset, sign and floor; register the result.
    rgbhsv_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_valid[NCELL]),
        .i_data       (w_data[NCELL]),
        .o_valid      (o_valid),
        .o_hue        (o_hue),
        .o_saturation (o_saturation),
        .o_brightness (o_brightness)
    );

    // An accepted transfer must enter the chain on the next cycle.
    `ASSERT_CLK(a_accept_enters, w_accept |=> w_valid[0], "accepted pixel not launched")
    // Results stay in range.
    `ASSERT_CLK(a_hue_range, o_valid |-> (o_hue < rgbhsv_pkg::FULL_TURN), "hue out of range")
    `ASSERT_CLK(a_sat_range, o_valid |-> (o_saturation <= rgbhsv_pkg::SAT_ONE),
                "saturation out of range")
    // Zero saturation means a grey pixel, which must also have zero hue.
    `ASSERT_CLK(a_grey_hue, (o_valid && (o_saturation == '0)) |-> (o_hue == '0),
                "grey pixel with nonzero hue")
    // Nothing leaves the pipeline in the cycle after reset.
    `ASSERT_ALWAYS(a_reset_flush, !$past(i_rst_n) |-> !o_valid, "valid out of reset")

endmodule
